/* design/mmts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mmts_pkg
// Shared types and codes for the min/max tracking stack.
// ----------------------------------------------------------------------------
package mmts_pkg;

    localparam int DefStackDepth = 64;
    localparam int WordWidth     = 32;

    typedef logic signed [WordWidth-1:0] t_word;

    localparam logic [1:0] OP_QUERY = 2'd0;
    localparam logic [1:0] OP_PUSH  = 2'd1;
    localparam logic [1:0] OP_POP   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_ctl;

    typedef struct packed {
        logic [1:0] status;
        logic       is_empty;
        t_word      top_value;
        t_word      min_value;
        t_word      max_value;
    } t_result;

endpackage
`default_nettype wire

/* design/min_max_tracking_stack.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// min_max_tracking_stack
// LIFO of signed words that also reports the running minimum and maximum.
//
// Input channel: i_valid / o_stall with i_opcode (query, push, pop) and
// i_push_value. Output channel: o_valid / i_stall with status, empty flag
// and the top, min and max after the operation.
// Three shift chains of cells (values, minima, maxima) keep their tops in
// cell 0, so each word is resolved in the cycle it is accepted.
// Each result is registered in the two-entry output queue before it appears.
// Throughput: one word per cycle while o_stall is low, set by the cell shift.
// A two-entry output queue holds results while the receiver stalls; input
// stalls only when both entries are occupied.
// Reset clears the element count and the output queue; the cell contents
// are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module min_max_tracking_stack
    import mmts_pkg::*;
#(
    parameter int STACK_DEPTH = DefStackDepth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire t_word       i_push_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic             o_is_empty,
    output t_word            o_top_value,
    output t_word            o_min_value,
    output t_word            o_max_value
);

    localparam int CntWidth = $clog2(STACK_DEPTH + 1);

    logic [CntWidth-1:0] r_count, n_count;
    logic                r_v0, r_v1;
    t_result             r_slot0, r_slot1;

    t_word      w_val0, w_val1, w_min0, w_min1, w_max0, w_max1;
    t_shift_ctl w_val_ctl, w_min_ctl, w_max_ctl;
    t_result    w_res;
    logic       w_acc, w_deq, w_empty, w_full, w_last;
    logic       w_do_push, w_do_pop, w_to_min, w_to_max;

    assign w_acc   = i_valid && !r_v1;
    assign w_deq   = r_v0 && !i_stall;
    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CntWidth'(STACK_DEPTH));
    assign w_last  = (r_count == CntWidth'(1));

    assign w_do_push = w_acc && (i_opcode == OP_PUSH) && !w_full;
    assign w_do_pop  = w_acc && (i_opcode == OP_POP) && !w_empty;
    assign w_to_min  = w_empty || (i_push_value <= w_min0);
    assign w_to_max  = w_empty || (i_push_value >= w_max0);

    assign w_val_ctl = '{push: w_do_push, pop: w_do_pop};
    assign w_min_ctl = '{push: w_do_push && w_to_min,
                         pop:  w_do_pop && (w_min0 == w_val0)};
    assign w_max_ctl = '{push: w_do_push && w_to_max,
                         pop:  w_do_pop && (w_max0 == w_val0)};

    mmts_chain #(.STACK_DEPTH(STACK_DEPTH)) u_val_chain (
        .i_clk(i_clk), .i_ctl(w_val_ctl), .i_push_word(i_push_value),
        .o_top0(w_val0), .o_top1(w_val1)
    );
    mmts_chain #(.STACK_DEPTH(STACK_DEPTH)) u_min_chain (
        .i_clk(i_clk), .i_ctl(w_min_ctl), .i_push_word(i_push_value),
        .o_top0(w_min0), .o_top1(w_min1)
    );
    mmts_chain #(.STACK_DEPTH(STACK_DEPTH)) u_max_chain (
        .i_clk(i_clk), .i_ctl(w_max_ctl), .i_push_word(i_push_value),
        .o_top0(w_max0), .o_top1(w_max1)
    );

    always_comb begin
        n_count           = r_count;
        w_res.status      = ST_OK;
        w_res.is_empty    = w_empty;
        w_res.top_value   = w_val0;
        w_res.min_value   = w_min0;
        w_res.max_value   = w_max0;
        unique case (i_opcode)
            OP_PUSH: begin
                if (w_full) begin
                    w_res.status = ST_FULL;
                end else begin
                    n_count         = r_count + CntWidth'(1);
                    w_res.is_empty  = 1'b0;
                    w_res.top_value = i_push_value;
                    if (w_to_min) begin
                        w_res.min_value = i_push_value;
                    end
                    if (w_to_max) begin
                        w_res.max_value = i_push_value;
                    end
                end
            end
            OP_POP: begin
                if (w_empty) begin
                    w_res.status = ST_EMPTY;
                end else begin
                    n_count         = r_count - CntWidth'(1);
                    w_res.is_empty  = w_last;
                    w_res.top_value = w_val1;
                    if (w_min_ctl.pop) begin
                        w_res.min_value = w_min1;
                    end
                    if (w_max_ctl.pop) begin
                        w_res.max_value = w_max1;
                    end
                end
            end
            default: begin
                if (w_empty) begin
                    w_res.status = ST_EMPTY;
                end
            end
        endcase
        if (w_res.is_empty) begin
            w_res.top_value = '0;
            w_res.min_value = '0;
            w_res.max_value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count <= n_count;
            end
            if (w_deq) begin
                r_v0 <= r_v1 || w_acc;
                r_v1 <= r_v1 && w_acc;
            end else if (w_acc) begin
                r_v0 <= 1'b1;
                r_v1 <= r_v0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_deq) begin
            r_slot0 <= r_v1 ? r_slot1 : w_res;
            r_slot1 <= w_res;
        end else if (w_acc) begin
            if (!r_v0) begin
                r_slot0 <= w_res;
            end else begin
                r_slot1 <= w_res;
            end
        end
    end

    assign o_stall     = r_v1;
    assign o_valid     = r_v0;
    assign o_status    = r_slot0.status;
    assign o_is_empty  = r_slot0.is_empty;
    assign o_top_value = r_slot0.top_value;
    assign o_min_value = r_slot0.min_value;
    assign o_max_value = r_slot0.max_value;

endmodule
`default_nettype wire

/* design/mmts_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mmts_cell
// One stack entry: loads its left neighbor on push, its right one on pop.
// ----------------------------------------------------------------------------
module mmts_cell
    import mmts_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_shift_ctl i_ctl,
    input  wire t_word      i_from_left,
    input  wire t_word      i_from_right,
    output t_word           o_value
);

    t_word r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_value <= i_from_left;
        end else if (i_ctl.pop) begin
            r_value <= i_from_right;
        end
    end

    assign o_value = r_value;

endmodule
`default_nettype wire

/* design/mmts_chain.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mmts_chain
// A row of cells forming one shift stack; cell 0 is the top.
// ----------------------------------------------------------------------------
module mmts_chain
    import mmts_pkg::*;
#(
    parameter int STACK_DEPTH = DefStackDepth
) (
    input  wire logic       i_clk,
    input  wire t_shift_ctl i_ctl,
    input  wire t_word      i_push_word,
    output t_word           o_top0,
    output t_word           o_top1
);

    t_word w_cell [STACK_DEPTH];

    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
            t_word w_left;
            t_word w_right;
            if (g == 0) begin : g_first
                assign w_left = i_push_word;
            end else begin : g_mid
                assign w_left = w_cell[g-1];
            end
            if (g == STACK_DEPTH - 1) begin : g_last
                assign w_right = w_cell[g];
            end else begin : g_inner
                assign w_right = w_cell[g+1];
            end
            mmts_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (i_ctl),
                .i_from_left  (w_left),
                .i_from_right (w_right),
                .o_value      (w_cell[g])
            );
        end
    endgenerate

    assign o_top0 = w_cell[0];
    assign o_top1 = w_cell[1];

endmodule
`default_nettype wire
